### hw/rtl/ftws_pkg.sv
// Shared constants and types for the frame time window statistics block.
`default_nettype none
package ftws_pkg;

  localparam int unsigned TIME_W     = 24;
  localparam int unsigned FPS_W      = 27;
  localparam int unsigned INTERVAL_W = 26;
  localparam int unsigned COUNT_W    = 32;

  localparam logic [FPS_W-1:0]      FPS_SCALE      = 27'd100000000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 26'd500000;
  localparam logic [TIME_W-1:0]     TIME_ALL_ONES  = '1;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

### hw/rtl/frame_time_window_statistics.sv
// Top level: frame time ring, running sums, min/max and windowed mean/deviation.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  op_i, frame_time_us_i
//   out      output     out_valid_o/out_stall_i all statistic fields
//   cfg      input      cfg_we_i               cfg_wdata_i (update interval)
//
// One request at a time. A frame passes through the ring read, the sum update with the
// ring write, then the 27-step serial frame rate divide. A recomputation adds the mean
// divide (SUM_W steps), three serial multiplies (2*NW + SUM_W steps), the variance divide
// (NUM_W steps), 24 square root steps and the hand-offs between them. No clearing pass
// after reset; the fill count guards the ring. Input is taken while a result waits in
// the output register.
`default_nettype none
module frame_time_window_statistics import ftws_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  op_i,
  input  wire logic [TIME_W-1:0]     frame_time_us_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [TIME_W-1:0]          current_time_us_o,
  output logic [FPS_W-1:0]           fps_centi_o,
  output logic [TIME_W-1:0]          min_time_us_o,
  output logic [TIME_W-1:0]          max_time_us_o,
  output logic [TIME_W-1:0]          mean_time_us_o,
  output logic [TIME_W-1:0]          std_dev_us_o,
  output logic [COUNT_W-1:0]         frames_total_o,
  output logic                       stats_updated_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [INTERVAL_W-1:0] cfg_wdata_i
);

  localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned NW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = TIME_W + NW;
  localparam int unsigned SQ_W  = 2 * TIME_W + NW;
  localparam int unsigned NUM_W = 2 * TIME_W + 2 * NW;
  localparam int unsigned DEN_W = (2 * NW > TIME_W) ? 2 * NW : TIME_W;
  localparam int unsigned IT_W  = $clog2(NUM_W + 1);
  localparam int unsigned MC_W  = $clog2(SUM_W + 1);
  localparam int unsigned VAR_W = 2 * TIME_W;
  localparam int unsigned RT_W  = TIME_W + 4;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_UPD  = 10'b0000000010,
    S_FPS  = 10'b0000000100,
    S_MEAN = 10'b0000001000,
    S_MNN  = 10'b0000010000,
    S_MP1  = 10'b0000100000,
    S_MP2  = 10'b0001000000,
    S_VAR  = 10'b0010000000,
    S_SQRT = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q;

  logic [TIME_W-1:0] ring_mem [WINDOW_DEPTH];
  logic [TIME_W-1:0] old_q;

  logic [INTERVAL_W-1:0] interval_q;
  logic [NW-1:0]         fill_q;
  logic [PTR_W-1:0]      wp_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SQ_W-1:0]       sq_q;
  logic [TIME_W-1:0]     last_q, min_q, max_q, mean_q, dev_q, t_q;
  logic [COUNT_W-1:0]    elapsed_q, frames_q;
  logic [FPS_W-1:0]      fps_q;
  logic                  upd_q;

  logic [SUM_W-1:0] ma_q;
  logic [SQ_W-1:0]  mb_q;
  logic [NUM_W-1:0] prod_q, p1_q;
  logic [MC_W-1:0]  mcnt_q;
  logic [2*NW-1:0]  nn_q;

  logic [VAR_W-1:0]  v_q;
  logic [RT_W-1:0]   srem_q;
  logic [TIME_W-1:0] root_q;
  logic [4:0]        scnt_q;

  logic             div_start_q;
  logic [NUM_W-1:0] div_num_q;
  logic [DEN_W-1:0] div_den_q;
  logic [IT_W-1:0]  div_iters_q;
  div_stat_t        div_stat;
  logic [NUM_W-1:0] div_quo;

  logic             accept, out_free, full;
  logic [SUM_W-1:0] sum_n;
  logic [SQ_W-1:0]  sq_n;
  logic [2*TIME_W-1:0] t_sq, old_sq;
  logic [COUNT_W:0]    el_sum;
  logic [COUNT_W-1:0]  el_sat;
  logic                hit;
  logic [RT_W+1:0]     srem_sh, strial;
  logic [SUM_W-1:0]    fill_al;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign full       = (fill_q == NW'(WINDOW_DEPTH));

  assign t_sq   = t_q * t_q;
  assign old_sq = old_q * old_q;
  assign sum_n  = sum_q + SUM_W'(t_q) - (full ? SUM_W'(old_q) : '0);
  assign sq_n   = sq_q + SQ_W'(t_sq) - (full ? SQ_W'(old_sq) : '0);
  assign el_sum = {1'b0, elapsed_q} + (COUNT_W+1)'(t_q);
  assign el_sat = el_sum[COUNT_W] ? '1 : el_sum[COUNT_W-1:0];
  assign hit    = el_sat >= COUNT_W'(interval_q);

  assign fill_al = {fill_q, {(SUM_W-NW){1'b0}}};
  assign srem_sh = {srem_q, v_q[VAR_W-1:VAR_W-2]};
  assign strial  = (RT_W+2)'({root_q, 2'b01});

  ftws_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .IT_W(IT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .iters_i (div_iters_q),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // ring: read the slot about to be overwritten at accept, write the new frame time to it next cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_q <= ring_mem[wp_q];
    end
    if (state_q == S_UPD) begin
      ring_mem[wp_q] <= t_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      wp_q        <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      last_q      <= '0;
      min_q       <= TIME_ALL_ONES;
      max_q       <= '0;
      mean_q      <= '0;
      dev_q       <= '0;
      elapsed_q   <= '0;
      frames_q    <= '0;
      fps_q       <= '0;
      upd_q       <= 1'b0;
      div_start_q <= 1'b0;
      mcnt_q      <= '0;
      scnt_q      <= '0;
      t_q         <= '0;
      ma_q        <= '0;
      mb_q        <= '0;
      prod_q      <= '0;
      p1_q        <= '0;
      nn_q        <= '0;
      v_q         <= '0;
      srem_q      <= '0;
      root_q      <= '0;
      div_num_q   <= '0;
      div_den_q   <= '0;
      div_iters_q <= '0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (op_i == OP_CLEAR) begin
              fill_q    <= '0;
              wp_q      <= '0;
              sum_q     <= '0;
              sq_q      <= '0;
              last_q    <= '0;
              min_q     <= TIME_ALL_ONES;
              max_q     <= '0;
              mean_q    <= '0;
              dev_q     <= '0;
              elapsed_q <= '0;
              frames_q  <= '0;
              fps_q     <= '0;
              upd_q     <= 1'b0;
              state_q   <= S_DONE;
            end else begin
              t_q     <= frame_time_us_i;
              state_q <= S_UPD;
            end
          end
        end
        S_UPD: begin
          sum_q  <= sum_n;
          sq_q   <= sq_n;
          if (!full) fill_q <= fill_q + 1'b1;
          wp_q   <= (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
          last_q <= t_q;
          if (t_q < min_q) min_q <= t_q;
          if (t_q > max_q) max_q <= t_q;
          frames_q  <= frames_q + 1'b1;
          elapsed_q <= hit ? '0 : el_sat;
          upd_q     <= hit;
          div_start_q <= 1'b1;
          div_num_q   <= NUM_W'(FPS_SCALE);
          div_den_q   <= DEN_W'(t_q);
          div_iters_q <= IT_W'(FPS_W);
          state_q     <= S_FPS;
        end
        S_FPS: begin
          if (div_stat.done) begin
            fps_q <= (t_q == '0) ? '0 : div_quo[FPS_W-1:0];
            if (upd_q) begin
              div_start_q <= 1'b1;
              div_num_q   <= NUM_W'(sum_q);
              div_den_q   <= DEN_W'(fill_q);
              div_iters_q <= IT_W'(SUM_W);
              state_q     <= S_MEAN;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_MEAN: begin
          if (div_stat.done) begin
            mean_q  <= div_quo[TIME_W-1:0];
            ma_q    <= fill_al;
            mb_q    <= SQ_W'(fill_q);
            prod_q  <= '0;
            mcnt_q  <= MC_W'(NW);
            state_q <= S_MNN;
          end
        end
        S_MNN, S_MP1, S_MP2: begin
          if (mcnt_q != '0) begin
            prod_q <= (prod_q << 1) + (ma_q[SUM_W-1] ? NUM_W'(mb_q) : '0);
            ma_q   <= ma_q << 1;
            mcnt_q <= mcnt_q - 1'b1;
          end else if (state_q == S_MNN) begin
            nn_q    <= prod_q[2*NW-1:0];
            ma_q    <= fill_al;
            mb_q    <= sq_q;
            prod_q  <= '0;
            mcnt_q  <= MC_W'(NW);
            state_q <= S_MP1;
          end else if (state_q == S_MP1) begin
            p1_q    <= prod_q;
            ma_q    <= sum_q;
            mb_q    <= SQ_W'(sum_q);
            prod_q  <= '0;
            mcnt_q  <= MC_W'(SUM_W);
            state_q <= S_MP2;
          end else begin
            div_start_q <= 1'b1;
            div_num_q   <= p1_q - prod_q;
            div_den_q   <= DEN_W'(nn_q);
            div_iters_q <= IT_W'(NUM_W);
            state_q     <= S_VAR;
          end
        end
        S_VAR: begin
          if (div_stat.done) begin
            v_q     <= div_quo[VAR_W-1:0];
            srem_q  <= '0;
            root_q  <= '0;
            scnt_q  <= 5'(TIME_W);
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          // one root bit per step from the top pair of radicand bits
          if (scnt_q != '0) begin
            v_q    <= v_q << 2;
            scnt_q <= scnt_q - 1'b1;
            if (srem_sh >= strial) begin
              srem_q <= RT_W'(srem_sh - strial);
              root_q <= {root_q[TIME_W-2:0], 1'b1};
            end else begin
              srem_q <= RT_W'(srem_sh);
              root_q <= {root_q[TIME_W-2:0], 1'b0};
            end
          end else begin
            dev_q   <= root_q;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      current_time_us_o <= last_q;
      fps_centi_o       <= fps_q;
      min_time_us_o     <= min_q;
      max_time_us_o     <= max_q;
      mean_time_us_o    <= mean_q;
      std_dev_us_o      <= dev_q;
      frames_total_o    <= frames_q;
      stats_updated_o   <= upd_q;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ftws_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module ftws_div import ftws_pkg::*; #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 26,
  parameter int unsigned IT_W  = $clog2(NUM_W + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [IT_W-1:0]  iters_i,
  output div_stat_t             stat_o,
  output logic      [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [IT_W-1:0]  cnt_q;
  logic             busy_q, done_q;

  logic [DEN_W:0]  rem_sh;
  logic            ge;
  logic [DEN_W:0]  rem_sub;
  logic [IT_W-1:0] shamt;

  assign rem_sh  = {rem_q, acc_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign shamt   = IT_W'(NUM_W) - iters_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == IT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // left-align the dividend so the quotient lands in the low bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i << shamt;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = acc_q;

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the frame time window statistics block.
`timescale 1ns / 1ps
module testbench import ftws_pkg::*; ();

  localparam int RING_DEPTH   = 128;
  localparam int SETTLE_CYCLES = 400;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;

  typedef struct {
    logic [TIME_W-1:0]  cur;
    logic [FPS_W-1:0]   fps;
    logic [TIME_W-1:0]  least;
    logic [TIME_W-1:0]  most;
    logic [TIME_W-1:0]  mean;
    logic [TIME_W-1:0]  dev;
    logic [COUNT_W-1:0] frames;
    logic               upd;
  } stats_t;

  typedef struct {
    logic              op;
    logic [TIME_W-1:0] dur;
    bit                typed;
    stats_t            exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = OP_RECORD;
  logic [TIME_W-1:0] frame_time_us_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [TIME_W-1:0] current_time_us_o, min_time_us_o, max_time_us_o;
  logic [TIME_W-1:0] mean_time_us_o, std_dev_us_o;
  logic [FPS_W-1:0] fps_centi_o;
  logic [COUNT_W-1:0] frames_total_o;
  logic stats_updated_o;
  logic cfg_we_i = 1'b0;
  logic [INTERVAL_W-1:0] cfg_wdata_i = '0;

  frame_time_window_statistics #(.WINDOW_DEPTH(RING_DEPTH)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .frame_time_us_i,
    .out_valid_o, .out_stall_i, .current_time_us_o, .fps_centi_o,
    .min_time_us_o, .max_time_us_o, .mean_time_us_o, .std_dev_us_o,
    .frames_total_o, .stats_updated_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("testbench failed");
    $finish;
  end

  // Model state
  logic [TIME_W-1:0]     hist [RING_DEPTH];
  int unsigned           fill;
  logic [6:0]            wptr;
  logic [63:0]           win_sum, win_sumsq;
  logic [TIME_W-1:0]     last_dur, least_dur, most_dur, mean_q, dev_q;
  logic [31:0]           elapsed, frame_cnt;
  logic [INTERVAL_W-1:0] interval;

  stats_t pending_stats[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void clear_model();
    fill = 0; wptr = 0; win_sum = 0; win_sumsq = 0;
    last_dur = 0; least_dur = TIME_ALL_ONES; most_dur = 0;
    mean_q = 0; dev_q = 0; elapsed = 0; frame_cnt = 0;
  endfunction

  function automatic stats_t predict_stats(logic op, logic [TIME_W-1:0] t);
    stats_t s;
    logic [127:0] num;
    logic [63:0] old, n;
    logic upd;
    upd = 1'b0;
    if (op == OP_CLEAR) begin
      clear_model();
    end else begin
      if (fill >= RING_DEPTH) begin
        old = hist[wptr];
        win_sum -= old;
        win_sumsq -= old * old;
      end else begin
        fill++;
      end
      hist[wptr] = t;
      win_sum += t;
      win_sumsq += 64'(t) * 64'(t);
      wptr = wptr + 1;
      last_dur = t;
      if (t < least_dur) least_dur = t;
      if (t > most_dur) most_dur = t;
      if (elapsed > 32'hFFFF_FFFF - t) elapsed = 32'hFFFF_FFFF;
      else elapsed += t;
      if (elapsed >= interval) begin
        n = fill;
        mean_q = TIME_W'(win_sum / n);
        num = 128'(n) * 128'(win_sumsq) - 128'(win_sum) * 128'(win_sum);
        dev_q = TIME_W'(floor_sqrt(64'(num / (128'(n) * 128'(n)))));
        elapsed = 0;
        upd = 1'b1;
      end
      frame_cnt++;
    end
    s.cur = last_dur;
    s.fps = (last_dur != 0) ? FPS_W'(32'd100000000 / last_dur) : '0;
    s.least = least_dur;
    s.most = most_dur;
    s.mean = mean_q;
    s.dev = dev_q;
    s.frames = frame_cnt;
    s.upd = upd;
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, act);
    end
  endfunction

  // Result monitor
  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: expected none, got cur %0d",
                 $time, current_time_us_o);
      end else begin
        e = pending_stats[0];
        pending_stats.delete(0);
        check_field("current_time_us", e.cur, current_time_us_o);
        check_field("fps_centi", e.fps, fps_centi_o);
        check_field("min_time_us", e.least, min_time_us_o);
        check_field("max_time_us", e.most, max_time_us_o);
        check_field("mean_time_us", e.mean, mean_time_us_o);
        check_field("std_dev_us", e.dev, std_dev_us_o);
        check_field("frames_total", e.frames, frames_total_o);
        check_field("stats_updated", e.upd, stats_updated_o);
      end
    end
  end

  // Receiver stall: long hold-off when requested, else random
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(logic op, logic [TIME_W-1:0] t, bit typed, stats_t exp);
    stats_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    frame_time_us_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    s = predict_stats(op, t);
    pending_stats.insert(pending_stats.size(), typed ? exp : s);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_interval(logic [INTERVAL_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    interval = v;
  endtask

  function automatic logic [TIME_W-1:0] rand_duration();
    case ($urandom_range(9))
      0: return '0;
      1: return TIME_ALL_ONES;
      2, 3: return TIME_W'($urandom);
      4: return TIME_W'($urandom_range(20000, 1000000));
      default: return TIME_W'($urandom_range(100, 50000));
    endcase
  endfunction

  task automatic random_phase(int items, int idle_pct, int stl_pct);
    stats_t none;
    send_idle_pct = idle_pct;
    stall_pct = stl_pct;
    none = '{default: '0};
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 3) send_request(OP_CLEAR, TIME_W'($urandom), 0, none);
      else send_request(OP_RECORD, rand_duration(), 0, none);
    end
  endtask

  row_t dir_rows[$];

  initial begin
    stats_t none, cleared;
    none = '{default: '0};
    cleared = '{cur: 0, fps: 0, least: TIME_ALL_ONES, most: 0, mean: 0, dev: 0,
                frames: 0, upd: 0};
    dir_rows = '{
      '{OP_CLEAR,  24'd0,        1, cleared},
      '{OP_RECORD, 24'd0,        1, '{0, 0, 0, 0, 0, 0, 1, 0}},
      '{OP_RECORD, TIME_ALL_ONES, 1, '{TIME_ALL_ONES, 5, 0, TIME_ALL_ONES,
                                      8388607, 8388607, 2, 1}},
      '{OP_RECORD, 24'd1,        1, '{1, 100000000, 0, TIME_ALL_ONES,
                                      8388607, 8388607, 3, 0}},
      '{OP_CLEAR,  TIME_ALL_ONES, 1, cleared},
      '{OP_RECORD, 24'd2,        0, none},
      '{OP_RECORD, 24'd16666,    0, none},
      '{OP_RECORD, 24'd16777214, 0, none},
      '{OP_RECORD, 24'd0,        0, none},
      '{OP_RECORD, 24'd499999,   0, none},
      '{OP_RECORD, 24'd1,        0, none},
      '{OP_RECORD, 24'hAAAAAA,   0, none},
      '{OP_RECORD, 24'h555555,   0, none},
      '{OP_RECORD, TIME_ALL_ONES, 0, none},
      '{OP_CLEAR,  24'h123456,   0, none},
      '{OP_RECORD, 24'd33333,    0, none}
    };

    for (int i = 0; i < RING_DEPTH; i++) hist[i] = '0;
    clear_model();
    interval = INTERVAL_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_request(dir_rows[i].op, dir_rows[i].dur,
                                       dir_rows[i].typed, dir_rows[i].exp);

    // every frame with a nonzero time recomputes
    write_interval(26'd1);
    random_phase(150, 0, 0);

    write_interval(INTERVAL_MAX);
    random_phase(150, 63, 0);

    // zero interval, so every frame recomputes
    write_interval('0);
    hold_cycles = 2000;
    random_phase(150, 0, 63);

    // sender pauses until every result is back
    drain();
    write_interval(INTERVAL_W'($urandom_range(20000, 300000)));
    random_phase(150, 22, 22);

    drain();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
